@@ design/tid_link_map_element_parser_defines.svh @@
// ----------------------------------------------------------------------------
// tid_link_map_element_parser_defines.svh
// Assertion macros used by the checker file of the element parser.
// ----------------------------------------------------------------------------
`ifndef TID_LINK_MAP_ELEMENT_PARSER_DEFINES_SVH
`define TID_LINK_MAP_ELEMENT_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TLMEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlmep assertion failed");

// next-cycle implication, disabled during reset
`define TLMEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlmep assertion failed");

`endif

@@ design/tlmep_pkg.sv @@
// ----------------------------------------------------------------------------
// tlmep_pkg
// Types, codes and helper functions of the TID-to-link mapping parser.
// ----------------------------------------------------------------------------
package tlmep_pkg;

    localparam int NUM_TIDS = 8;
    localparam int TDATA_W  = 80;
    localparam logic [7:0] CTRL_MASK = 8'h3F;

    localparam logic KIND_MAP     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_CONTROL  = 3'd0,
        PH_PRESENCE = 3'd1,
        PH_SWITCH   = 3'd2,
        PH_DURATION = 3'd3,
        PH_MAPPING  = 3'd4,
        PH_DONE     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_EXCESS = 2'd2
    } status_t;

    typedef struct packed {
        logic        last_result;
        logic [1:0]  status;
        logic [7:0]  presence_bits;
        logic [23:0] duration_tu;
        logic        duration_present;
        logic [15:0] switch_time_tu;
        logic        switch_present;
        logic        default_mapping;
        logic [1:0]  direction;
        logic [15:0] link_bitmap;
        logic [2:0]  tid;
        logic        result_kind;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        phase_t     phase;
        logic       tid_load;
        logic [2:0] tid;
    } adv_t;

    // lowest set presence bit at or above from; bit 3 set means none
    function automatic logic [3:0] first_tid(input logic [7:0] pres, input logic [3:0] from);
        logic [3:0] r;
        r = 4'(NUM_TIDS);
        for (int t = NUM_TIDS - 1; t >= 0; t--)
        begin
            if (4'(t) >= from && pres[t])
            begin
                r = 4'(t);
            end
        end
        return r;
    endfunction

    // section that follows the one just completed
    function automatic adv_t advance(input phase_t done, input logic [5:0] ctrl,
                                     input logic [7:0] pres);
        adv_t       a;
        logic [3:0] ft;
        a.phase    = PH_DONE;
        a.tid_load = 1'b0;
        a.tid      = 3'd0;
        ft         = first_tid(pres, 4'd0);
        if (done < PH_PRESENCE && !ctrl[2])
        begin
            a.phase = PH_PRESENCE;
        end
        else if (done < PH_SWITCH && ctrl[3])
        begin
            a.phase = PH_SWITCH;
        end
        else if (done < PH_DURATION && ctrl[4])
        begin
            a.phase = PH_DURATION;
        end
        else if (!ft[3])
        begin
            a.phase    = PH_MAPPING;
            a.tid_load = 1'b1;
            a.tid      = ft[2:0];
        end
        return a;
    endfunction

endpackage

@@ design/tlmep_parser.sv @@
// ----------------------------------------------------------------------------
// tlmep_parser
// Parse state of the element and per-byte decode into zero to two results.
// ----------------------------------------------------------------------------
module tlmep_parser
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       data_byte,
    input  logic             is_last,
    output tlmep_pkg::push_t push
);

    tlmep_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [5:0]  ctrl_reg, ctrl_next;
    logic [7:0]  pres_reg, pres_next;
    logic [2:0]  tid_reg, tid_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] sw_reg, sw_next;
    logic [23:0] dur_reg, dur_next;
    logic        excess_reg, excess_next;

    tlmep_pkg::adv_t    adv;
    tlmep_pkg::result_t ctx;
    logic               map_done;
    logic [15:0]        bitmap;
    logic [3:0]         ft;
    logic [1:0]         status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tlmep_pkg::PH_CONTROL;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            ctrl_reg   <= '0;
            pres_reg   <= '0;
            tid_reg    <= '0;
            low_reg    <= '0;
            sw_reg     <= '0;
            dur_reg    <= '0;
            excess_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg    <= idx_next;
            ctrl_reg   <= ctrl_next;
            pres_reg   <= pres_next;
            tid_reg    <= tid_next;
            low_reg    <= low_next;
            sw_reg     <= sw_next;
            dur_reg    <= dur_next;
            excess_reg <= excess_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        ctrl_next   = ctrl_reg;
        pres_next   = pres_reg;
        tid_next    = tid_reg;
        low_next    = low_reg;
        sw_next     = sw_reg;
        dur_next    = dur_reg;
        excess_next = excess_reg;
        map_done    = 1'b0;
        bitmap      = '0;
        adv         = '0;
        ft          = tlmep_pkg::first_tid(pres_reg, {1'b0, tid_reg} + 4'd1);

        case (phase_reg)
            tlmep_pkg::PH_CONTROL:
            begin
                ctrl_next = 6'(data_byte & tlmep_pkg::CTRL_MASK);
                adv       = tlmep_pkg::advance(tlmep_pkg::PH_CONTROL, ctrl_next, pres_reg);
            end
            tlmep_pkg::PH_PRESENCE:
            begin
                pres_next = data_byte;
                adv       = tlmep_pkg::advance(tlmep_pkg::PH_PRESENCE, ctrl_reg, pres_next);
            end
            tlmep_pkg::PH_SWITCH:
            begin
                if (idx_reg == 2'd0)
                begin
                    sw_next  = {8'h00, data_byte};
                    idx_next = 2'd1;
                end
                else
                begin
                    sw_next = {data_byte, sw_reg[7:0]};
                    adv     = tlmep_pkg::advance(tlmep_pkg::PH_SWITCH, ctrl_reg, pres_reg);
                end
            end
            tlmep_pkg::PH_DURATION:
            begin
                case (idx_reg)
                    2'd0:    dur_next[7:0]   = dur_reg[7:0] | data_byte;
                    2'd1:    dur_next[15:8]  = dur_reg[15:8] | data_byte;
                    2'd2:    dur_next[23:16] = dur_reg[23:16] | data_byte;
                    default: dur_next        = dur_reg;
                endcase
                if (idx_reg >= 2'd2)
                begin
                    adv = tlmep_pkg::advance(tlmep_pkg::PH_DURATION, ctrl_reg, pres_reg);
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            tlmep_pkg::PH_MAPPING:
            begin
                if (ctrl_reg[5])
                begin
                    bitmap   = {8'h00, data_byte};
                    map_done = 1'b1;
                end
                else if (idx_reg == 2'd0)
                begin
                    low_next = data_byte;
                    idx_next = 2'd1;
                end
                else
                begin
                    bitmap   = {data_byte, low_reg};
                    map_done = 1'b1;
                end
                if (map_done)
                begin
                    idx_next = 2'd0;
                    if (!ft[3])
                    begin
                        tid_next = ft[2:0];
                    end
                    else
                    begin
                        phase_next = tlmep_pkg::PH_DONE;
                    end
                end
            end
            default:
            begin
                excess_next = 1'b1;
            end
        endcase

        if (adv.phase != tlmep_pkg::PH_CONTROL)
        begin
            phase_next = adv.phase;
            idx_next   = 2'd0;
            if (adv.tid_load)
            begin
                tid_next = adv.tid;
            end
        end

        ctx.last_result      = 1'b0;
        ctx.status           = tlmep_pkg::ST_OK;
        ctx.presence_bits    = pres_next;
        ctx.duration_tu      = dur_next;
        ctx.duration_present = ctrl_next[4];
        ctx.switch_time_tu   = sw_next;
        ctx.switch_present   = ctrl_next[3];
        ctx.default_mapping  = ctrl_next[2];
        ctx.direction        = ctrl_next[1:0];
        ctx.link_bitmap      = '0;
        ctx.tid              = '0;
        ctx.result_kind      = tlmep_pkg::KIND_SUMMARY;

        if (excess_next)
        begin
            status = tlmep_pkg::ST_EXCESS;
        end
        else if (phase_next >= tlmep_pkg::PH_DONE)
        begin
            status = tlmep_pkg::ST_OK;
        end
        else
        begin
            status = tlmep_pkg::ST_SHORT;
        end

        push.count = {1'b0, map_done} + {1'b0, is_last};
        push.r1    = ctx;
        push.r1.status      = status;
        push.r1.last_result = 1'b1;
        if (map_done)
        begin
            push.r0             = ctx;
            push.r0.result_kind = tlmep_pkg::KIND_MAP;
            push.r0.tid         = tid_reg;
            push.r0.link_bitmap = bitmap;
            push.r0.last_result = !is_last;
        end
        else
        begin
            push.r0 = push.r1;
        end

        if (is_last)
        begin
            phase_next  = tlmep_pkg::PH_CONTROL;
            idx_next    = '0;
            ctrl_next   = '0;
            pres_next   = '0;
            tid_next    = '0;
            low_next    = '0;
            sw_next     = '0;
            dur_next    = '0;
            excess_next = 1'b0;
        end
    end

endmodule

@@ design/tlmep_out_fifo.sv @@
// ----------------------------------------------------------------------------
// tlmep_out_fifo
// Result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module tlmep_out_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_en,
    input  tlmep_pkg::push_t   push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output tlmep_pkg::result_t out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlmep_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [1:0]         n;
    logic               pop;

    function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign n          = push_en ? push.count : 2'd0;
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = inc(wr_ptr_reg);
    assign out_valid  = count_reg != '0;
    assign out_data   = mem_reg[rd_ptr_reg];
    assign room       = count_reg <= CNT_W'(DEPTH - 2);

    always_comb
    begin
        case (n)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (n == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

endmodule

@@ design/tid_link_map_element_parser.sv @@
// Results enter the result queue on the edge that accepts their byte and leave in order.
// Throughput: one byte per cycle while the result queue keeps two free slots; a byte
// that closes a mapping and ends the element writes both results into the queue at once.
// The output queue (FIFO_DEPTH entries, one read per cycle) sets the sustained rate.
// Reset: rst_n clears the parse state and empties the result queue at once.
// ----------------------------------------------------------------------------
// tid_link_map_element_parser
// Byte-serial parser of a TID-to-link mapping element information field.
// ----------------------------------------------------------------------------
module tid_link_map_element_parser
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // data_byte
    input  logic                          s_axis_tlast,  // is_last
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tid, link_bitmap, direction, default_mapping, switch_present, switch_time_tu,
    // duration_present, duration_tu, presence_bits, status, zero pad
    output logic [tlmep_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser,  // result_kind
    output logic                          m_axis_tlast   // last_result
);

    tlmep_pkg::push_t   push;
    tlmep_pkg::result_t res;
    logic               fire;

    assign fire = s_axis_tvalid && s_axis_tready;

    tlmep_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (s_axis_tdata),
        .is_last   (s_axis_tlast),
        .push      (push)
    );

    tlmep_out_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (fire),
        .push      (push),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {6'd0, res.status, res.presence_bits, res.duration_tu,
                           res.duration_present, res.switch_time_tu, res.switch_present,
                           res.default_mapping, res.direction, res.link_bitmap, res.tid};
    assign m_axis_tuser = res.result_kind;
    assign m_axis_tlast = res.last_result;

endmodule

@@ design/tlmep_checker.sv @@
// ----------------------------------------------------------------------------
// tlmep_checker
// Port-level checks of the element parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "tid_link_map_element_parser_defines.svh"

module tlmep_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [7:0]                    s_axis_tdata,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [tlmep_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ s_axis_tlast;

    `TLMEP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `TLMEP_ASSERT_NOW(a_summary_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    `TLMEP_ASSERT_NOW(a_summary_clear, m_axis_tvalid && m_axis_tuser, m_axis_tdata[18:0] == 19'd0)
    `TLMEP_ASSERT_NOW(a_map_status, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[73:72] == 2'd0)
    `TLMEP_ASSERT_NOW(a_default_no_pres, m_axis_tvalid && m_axis_tdata[21],
                      m_axis_tdata[71:64] == 8'd0)

endmodule

bind tid_link_map_element_parser tlmep_checker u_tlmep_checker (.*);

@@ test/tlmep_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlmep_result_checker
// Watches both streams of the element parser, decodes every accepted byte
// into the results it should cause, and compares each result transaction
// field by field against the oldest one still waiting.
// ----------------------------------------------------------------------------
module tlmep_result_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tlmep_pkg::TDATA_W-1:0] m_tdata,
    input  logic                          m_tuser,
    input  logic                          m_tlast,
    output int                            errors,
    output int                            pending
);

    tlmep_pkg::phase_t  ph;
    logic [1:0]         byte_idx;
    logic [5:0]         ctrl;
    logic [7:0]         pres;
    logic [2:0]         tid_cur;
    logic [7:0]         low_byte;
    logic [15:0]        sw_time;
    logic [23:0]        dur;
    logic               excess;
    tlmep_pkg::result_t expected_results[$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [23:0] got,
                                 input logic [23:0] want);
        if (got !== want)
        begin
            report($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    function automatic logic [3:0] lowest_tid_from(input logic [7:0] map, input int start);
        for (int t = start; t < tlmep_pkg::NUM_TIDS; t++)
        begin
            if (map[t])
            begin
                return 4'(t);
            end
        end
        return 4'(tlmep_pkg::NUM_TIDS);
    endfunction

    task automatic clear_parse();
        ph       = tlmep_pkg::PH_CONTROL;
        byte_idx = 2'd0;
        ctrl     = 6'd0;
        pres     = 8'd0;
        tid_cur  = 3'd0;
        low_byte = 8'd0;
        sw_time  = 16'd0;
        dur      = 24'd0;
        excess   = 1'b0;
    endtask

    task automatic next_section(input tlmep_pkg::phase_t done);
        logic [3:0] first;
        first    = lowest_tid_from(pres, 0);
        byte_idx = 2'd0;
        if (done < tlmep_pkg::PH_PRESENCE && !ctrl[2])
        begin
            ph = tlmep_pkg::PH_PRESENCE;
        end
        else if (done < tlmep_pkg::PH_SWITCH && ctrl[3])
        begin
            ph = tlmep_pkg::PH_SWITCH;
        end
        else if (done < tlmep_pkg::PH_DURATION && ctrl[4])
        begin
            ph = tlmep_pkg::PH_DURATION;
        end
        else if (first < tlmep_pkg::NUM_TIDS)
        begin
            tid_cur = first[2:0];
            ph      = tlmep_pkg::PH_MAPPING;
        end
        else
        begin
            ph = tlmep_pkg::PH_DONE;
        end
    endtask

    function automatic tlmep_pkg::result_t make_result(input logic kind, input logic [2:0] t,
                                                       input logic [15:0] bm,
                                                       input logic [1:0] st);
        tlmep_pkg::result_t r;
        r.result_kind      = kind;
        r.tid              = t;
        r.link_bitmap      = bm;
        r.direction        = ctrl[1:0];
        r.default_mapping  = ctrl[2];
        r.switch_present   = ctrl[3];
        r.switch_time_tu   = sw_time;
        r.duration_present = ctrl[4];
        r.duration_tu      = dur;
        r.presence_bits    = pres;
        r.status           = st;
        r.last_result      = 1'b0;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        tlmep_pkg::result_t map_res;
        tlmep_pkg::result_t sum_res;
        logic               have_map;
        logic [15:0]        bm;
        logic [3:0]         nxt;
        logic [1:0]         st;
        have_map = 1'b0;
        bm       = 16'd0;
        case (ph)
            tlmep_pkg::PH_CONTROL:
            begin
                ctrl = b[5:0];
                next_section(tlmep_pkg::PH_CONTROL);
            end
            tlmep_pkg::PH_PRESENCE:
            begin
                pres = b;
                next_section(tlmep_pkg::PH_PRESENCE);
            end
            tlmep_pkg::PH_SWITCH:
            begin
                if (byte_idx == 2'd0)
                begin
                    sw_time  = {8'h00, b};
                    byte_idx = 2'd1;
                end
                else
                begin
                    sw_time = {b, sw_time[7:0]};
                    next_section(tlmep_pkg::PH_SWITCH);
                end
            end
            tlmep_pkg::PH_DURATION:
            begin
                dur = dur | (24'(b) << (8 * byte_idx));
                if (byte_idx >= 2'd2)
                begin
                    next_section(tlmep_pkg::PH_DURATION);
                end
                else
                begin
                    byte_idx++;
                end
            end
            tlmep_pkg::PH_MAPPING:
            begin
                if (ctrl[5])
                begin
                    bm       = {8'h00, b};
                    have_map = 1'b1;
                end
                else if (byte_idx == 2'd0)
                begin
                    low_byte = b;
                    byte_idx = 2'd1;
                end
                else
                begin
                    bm       = {b, low_byte};
                    have_map = 1'b1;
                end
                if (have_map)
                begin
                    map_res  = make_result(tlmep_pkg::KIND_MAP, tid_cur, bm, tlmep_pkg::ST_OK);
                    byte_idx = 2'd0;
                    nxt      = lowest_tid_from(pres, int'(tid_cur) + 1);
                    if (nxt < tlmep_pkg::NUM_TIDS)
                    begin
                        tid_cur = nxt[2:0];
                    end
                    else
                    begin
                        ph = tlmep_pkg::PH_DONE;
                    end
                end
            end
            default:
            begin
                excess = 1'b1;
            end
        endcase

        if (have_map)
        begin
            map_res.last_result = !fin;
            expected_results.push_back(map_res);
        end
        if (fin)
        begin
            if (excess)
            begin
                st = tlmep_pkg::ST_EXCESS;
            end
            else if (ph == tlmep_pkg::PH_DONE)
            begin
                st = tlmep_pkg::ST_OK;
            end
            else
            begin
                st = tlmep_pkg::ST_SHORT;
            end
            sum_res             = make_result(tlmep_pkg::KIND_SUMMARY, 3'd0, 16'd0, st);
            sum_res.last_result = 1'b1;
            expected_results.push_back(sum_res);
            clear_parse();
        end
    endtask

    task automatic check_result();
        tlmep_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            report($sformatf("result with nothing expected, tdata %0h", m_tdata));
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("result_kind", m_tuser, want.result_kind);
            compare_field("tid", m_tdata[2:0], want.tid);
            compare_field("link_bitmap", m_tdata[18:3], want.link_bitmap);
            compare_field("direction", m_tdata[20:19], want.direction);
            compare_field("default_mapping", m_tdata[21], want.default_mapping);
            compare_field("switch_present", m_tdata[22], want.switch_present);
            compare_field("switch_time_tu", m_tdata[38:23], want.switch_time_tu);
            compare_field("duration_present", m_tdata[39], want.duration_present);
            compare_field("duration_tu", m_tdata[63:40], want.duration_tu);
            compare_field("presence_bits", m_tdata[71:64], want.presence_bits);
            compare_field("status", m_tdata[73:72], want.status);
            compare_field("tdata pad", m_tdata[79:74], 24'd0);
            compare_field("last_result", m_tlast, want.last_result);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            pending <= expected_results.size();
        end
    end

endmodule

@@ test/tb_tid_link_map_element_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tid_link_map_element_parser
// Feeds TID-to-link mapping elements byte by byte: a few hand-built ones,
// then random elements, mostly well formed, some cut short, some overlong,
// plus random noise, with random idle gaps on input and output.
// ----------------------------------------------------------------------------
module tb_tid_link_map_element_parser;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int BYTE_TARGET  = 1225;

    logic                          clk;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = 8'h00;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tlmep_pkg::TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;

    int         errors;
    int         pending;
    int         cycles     = 0;
    int         bytes_sent = 0;
    bit         calm       = 1'b0;
    int         stall_left = 0;
    bit         ready_calm = 1'b0;
    logic [7:0] frame_bytes[$];

    tid_link_map_element_parser u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    tlmep_result_checker u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // output backpressure
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
        begin
            ready_calm = !ready_calm;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!ready_calm && $urandom_range(0, 99) < 30)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic build_frame();
        logic [7:0] ctrl;
        logic [7:0] pres;
        int         shape;
        int         keep;
        ctrl  = 8'($urandom_range(0, 255));
        shape = $urandom_range(0, 99);
        pres  = 8'h00;
        frame_bytes.delete();
        frame_bytes.push_back(ctrl);
        if (!ctrl[2])
        begin
            case ($urandom_range(0, 9))
                0:       pres = 8'h00;
                1:       pres = 8'hFF;
                default: pres = 8'($urandom_range(0, 255));
            endcase
            frame_bytes.push_back(pres);
        end
        if (ctrl[3])
        begin
            repeat (2) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (ctrl[4])
        begin
            repeat (3) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        for (int t = 0; t < 8; t++)
        begin
            if (pres[t])
            begin
                repeat (ctrl[5] ? 1 : 2) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (shape < 15 && frame_bytes.size() > 1)
        begin
            keep = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > keep)
            begin
                void'(frame_bytes.pop_back());
            end
        end
        else if (shape < 30)
        begin
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_noise();
        frame_bytes.delete();
        repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default mapping, nothing else: complete after the control byte
        frame_bytes = '{8'h04};
        send_frame();
        // all control bits set, reserved bits too, all-ones times
        frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        // empty presence bitmap
        frame_bytes = '{8'h00, 8'h00};
        send_frame();
        // lowest and highest TID, 2-byte bitmaps, mapping closes on the last byte
        frame_bytes = '{8'h01, 8'h81, 8'h00, 8'h00, 8'hFF, 8'hFF};
        send_frame();
        // 1-byte bitmap followed by an excess byte
        frame_bytes = '{8'h22, 8'h01, 8'hA5, 8'h5A};
        send_frame();
        // ends on half a 2-byte bitmap
        frame_bytes = '{8'h00, 8'h02, 8'h3C};
        send_frame();
        // ends before the expected duration
        frame_bytes = '{8'h58, 8'h00, 8'h34, 8'h12};
        send_frame();

        while (bytes_sent < BYTE_TARGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85)
            begin
                build_frame();
            end
            else
            begin
                build_noise();
            end
            send_frame();
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
